/* hdl/hti_pkg.sv */
// shared constants, codes and types for the heightmap triangle interpolator
// depends on nothing; imported by every module of the block
package hti_pkg;

  // grid geometry
  localparam int GRID_CELLS   = 128;
  localparam int CORNER_SIDE  = GRID_CELLS + 1;
  localparam int CORNER_DEPTH = CORNER_SIDE * CORNER_SIDE;
  localparam int CENTRE_DEPTH = GRID_CELLS * GRID_CELLS;

  // field widths
  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 15;
  localparam int SAMPLE_W  = 16;
  localparam int CELL_W    = 7;
  localparam int FRAC_W    = 16;
  localparam int OUT_W     = 40;
  localparam int CORNER_AW = 15;
  localparam int CENTRE_AW = 14;

  // datapath widths
  localparam int COEF_W = 19;
  localparam int PROD_W = 36;
  localparam int ACC_W  = 38;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 2'd1;

  // commands
  localparam logic [CMD_W-1:0] CMD_WR_CORNER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_CENTRE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;

  // height modes
  localparam logic [1:0] MODE_FLAT = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;

  // sequencer strobes toward the plane unit
  typedef struct packed {
    logic hold_en;
    logic coef_en;
    logic mulx_en;
    logic sum_en;
  } hti_step_t;

  // query fields held for the length of one query
  typedef struct packed {
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;
    logic              lower;
    logic              x_gt_y;
    logic [1:0]        mode;
  } hti_query_t;

endpackage

/* hdl/heightmap_triangle_interpolator_unit.sv */
// top level of the heightmap triangle interpolator: handshakes, config registers, sequencer
// depends on hti_pkg, hti_sample_store and hti_plane_unit

// Keeps a 129x129 grid of corner heights and a 128x128 grid of centre heights in two
// synchronous memories, loaded one sample per beat, and answers height queries in signed
// Q.16. A sample write is written at the edge that accepts it and the block is ready again
// in the next cycle. A query's result enters the output register once that is free, and the
// next beat is taken once it has moved there. The steps are the two reads of the corner
// memory's single read port (the centre sample comes with the first), then coefficient,
// two multiply and final stages. Sample memories come up undefined and need no clearing; a
// query may only touch samples already written. The output register lets a new beat be
// accepted while a result still waits downstream. Configuration registers (height mode,
// base height) may be written while the block is idle.
module heightmap_triangle_interpolator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [hti_pkg::CMD_W-1:0]            command_i,
  input  logic [hti_pkg::INDEX_W-1:0]          entry_index_i,
  input  logic [hti_pkg::SAMPLE_W-1:0]         entry_value_i,
  input  logic [hti_pkg::CELL_W-1:0]           cell_x_i,
  input  logic [hti_pkg::CELL_W-1:0]           cell_y_i,
  input  logic [hti_pkg::FRAC_W-1:0]           frac_x_i,
  input  logic [hti_pkg::FRAC_W-1:0]           frac_y_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [hti_pkg::OUT_W-1:0]     height_o,
  // configuration channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [hti_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [hti_pkg::OUT_W-1:0]            cfg_data_i
);
  import hti_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD2  = 3'd1;
  localparam logic [2:0] S_COEF = 3'd2;
  localparam logic [2:0] S_MULX = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [1:0]                height_mode_q;
  logic signed [OUT_W-1:0]   base_height_q;
  hti_query_t                query_q;
  logic [CORNER_AW-1:0]      base_q;
  logic                      out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0]   height_q;

  logic                      in_beat;
  logic                      query_beat;
  logic                      out_free;
  logic [FRAC_W:0]           frac_sum;
  logic                      lower_in;
  logic                      x_gt_y_in;
  logic [CORNER_AW-1:0]      base_in;
  logic [CORNER_AW-1:0]      addr_first;
  logic [CORNER_AW-1:0]      addr_second;
  logic                      corner_we;
  logic                      centre_we;
  logic                      rd_en;
  logic [CORNER_AW-1:0]      corner_raddr;
  logic [CENTRE_AW-1:0]      centre_raddr;
  logic [SAMPLE_W-1:0]       corner_rd;
  logic [SAMPLE_W-1:0]       centre_rd;
  hti_step_t                 step;
  logic signed [OUT_W-1:0]   plane_height;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign query_beat  = in_beat && (command_i == CMD_QUERY);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // triangle choice from fraction sum and order
  assign frac_sum  = {1'b0, frac_x_i} + {1'b0, frac_y_i};
  assign lower_in  = !frac_sum[FRAC_W];
  assign x_gt_y_in = frac_x_i > frac_y_i;

  // corner row base: cell_x * 129 + cell_y as a shift and two adds
  assign base_in = CORNER_AW'({cell_x_i, {CELL_W{1'b0}}}) + CORNER_AW'(cell_x_i)
                 + CORNER_AW'(cell_y_i);

  // first read: h1 in the lower half, h4 in the upper; second read: h2 or h3
  assign addr_first  = lower_in ? base_in : base_in + CORNER_AW'(CORNER_SIDE + 1);
  assign addr_second = query_q.x_gt_y ? base_q + CORNER_AW'(CORNER_SIDE)
                                      : base_q + CORNER_AW'(1);

  assign corner_we = in_beat && (command_i == CMD_WR_CORNER)
                  && (entry_index_i < INDEX_W'(CORNER_DEPTH));
  assign centre_we = in_beat && (command_i == CMD_WR_CENTRE)
                  && (entry_index_i < INDEX_W'(CENTRE_DEPTH));

  assign rd_en        = query_beat || (state_q == S_RD2);
  assign corner_raddr = (state_q == S_IDLE) ? addr_first : addr_second;
  assign centre_raddr = {cell_x_i, cell_y_i};

  assign step.hold_en = (state_q == S_RD2);
  assign step.coef_en = (state_q == S_COEF);
  assign step.mulx_en = (state_q == S_MULX);
  assign step.sum_en  = (state_q == S_SUM);

  hti_sample_store u_store (
    .clk_i          (clk_i),
    .corner_we_i    (corner_we),
    .centre_we_i    (centre_we),
    .wr_addr_i      (entry_index_i),
    .wr_data_i      (entry_value_i),
    .rd_en_i        (rd_en),
    .corner_raddr_i (corner_raddr),
    .centre_raddr_i (centre_raddr),
    .corner_rd_o    (corner_rd),
    .centre_rd_o    (centre_rd)
  );

  hti_plane_unit u_plane (
    .clk_i         (clk_i),
    .step_i        (step),
    .query_i       (query_q),
    .corner_rd_i   (corner_rd),
    .centre_rd_i   (centre_rd),
    .base_height_i (base_height_q),
    .height_o      (plane_height)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (query_beat) begin
          state_d = S_RD2;
        end
      end
      S_RD2:  state_d = S_COEF;
      S_COEF: state_d = S_MULX;
      S_MULX: state_d = S_SUM;
      S_SUM:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result register valid: load wins over a drain in the same cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == S_OUT) && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      height_mode_q <= MODE_FLAT;
      base_height_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_HEIGHT_MODE) begin
          height_mode_q <= cfg_data_i[1:0];
        end else if (cfg_index_i == REG_BASE_HEIGHT) begin
          base_height_q <= cfg_data_i;
        end
      end
    end
  end

  // query payload and result payload
  always_ff @(posedge clk_i) begin
    if (query_beat) begin
      query_q.frac_x <= frac_x_i;
      query_q.frac_y <= frac_y_i;
      query_q.lower  <= lower_in;
      query_q.x_gt_y <= x_gt_y_in;
      query_q.mode   <= height_mode_q;
      base_q         <= base_in;
    end
    if ((state_q == S_OUT) && out_free) begin
      height_q <= plane_height;
    end
  end

  assign out_valid_o = out_valid_q;
  assign height_o    = height_q;

endmodule

/* hdl/hti_sample_store.sv */
// corner and centre sample memories, one write port and one registered read port each
// depends on hti_pkg
module hti_sample_store (
  input  logic                              clk_i,
  input  logic                              corner_we_i,
  input  logic                              centre_we_i,
  input  logic [hti_pkg::CORNER_AW-1:0]     wr_addr_i,
  input  logic [hti_pkg::SAMPLE_W-1:0]      wr_data_i,
  input  logic                              rd_en_i,
  input  logic [hti_pkg::CORNER_AW-1:0]     corner_raddr_i,
  input  logic [hti_pkg::CENTRE_AW-1:0]     centre_raddr_i,
  output logic [hti_pkg::SAMPLE_W-1:0]      corner_rd_o,
  output logic [hti_pkg::SAMPLE_W-1:0]      centre_rd_o
);
  import hti_pkg::*;

  logic [SAMPLE_W-1:0] corner_mem [CORNER_DEPTH];
  logic [SAMPLE_W-1:0] centre_mem [CENTRE_DEPTH];
  logic [SAMPLE_W-1:0] corner_rd_q;
  logic [SAMPLE_W-1:0] centre_rd_q;

  always_ff @(posedge clk_i) begin
    if (corner_we_i) begin
      corner_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      corner_rd_q <= corner_mem[corner_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (centre_we_i) begin
      centre_mem[wr_addr_i[CENTRE_AW-1:0]] <= wr_data_i;
    end
    if (rd_en_i) begin
      centre_rd_q <= centre_mem[centre_raddr_i];
    end
  end

  assign corner_rd_o = corner_rd_q;
  assign centre_rd_o = centre_rd_q;

endmodule

/* hdl/hti_plane_unit.sv */
// plane fit over one triangle: coefficients, two multiply stages, scale, base add, saturate
// depends on hti_pkg
module hti_plane_unit (
  input  logic                                clk_i,
  input  hti_pkg::hti_step_t                  step_i,
  input  hti_pkg::hti_query_t                 query_i,
  input  logic [hti_pkg::SAMPLE_W-1:0]        corner_rd_i,
  input  logic [hti_pkg::SAMPLE_W-1:0]        centre_rd_i,
  input  logic signed [hti_pkg::OUT_W-1:0]    base_height_i,
  output logic signed [hti_pkg::OUT_W-1:0]    height_o
);
  import hti_pkg::*;

  logic [SAMPLE_W-1:0]      hold_a_q;
  logic [SAMPLE_W-1:0]      hold_c_q;
  logic [SAMPLE_W-1:0]      smp_a;
  logic [SAMPLE_W-1:0]      smp_b;
  logic [SAMPLE_W-1:0]      smp_c;
  logic                     low_byte;
  logic signed [COEF_W-1:0] ha, hb, h5;
  logic signed [COEF_W-1:0] a_d, b_d, c_d;
  logic signed [COEF_W-1:0] a_q, b_q, c_q;
  logic signed [FRAC_W:0]   x_s, y_s;
  logic signed [PROD_W-1:0] ax_prod, by_prod;
  logic signed [PROD_W-1:0] ax_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [OUT_W:0]    scaled;
  logic signed [OUT_W:0]    total;

  // first corner and centre arrive ahead of the second corner and are held here
  always_ff @(posedge clk_i) begin
    if (step_i.hold_en) begin
      hold_a_q <= corner_rd_i;
      hold_c_q <= centre_rd_i;
    end
  end

  assign low_byte = (query_i.mode == MODE_BYTE);
  assign smp_a = low_byte ? {8'h00, hold_a_q[7:0]}    : hold_a_q;
  assign smp_b = low_byte ? {8'h00, corner_rd_i[7:0]} : corner_rd_i;
  assign smp_c = low_byte ? {8'h00, hold_c_q[7:0]}    : hold_c_q;

  assign ha = $signed({{(COEF_W-SAMPLE_W){1'b0}}, smp_a});
  assign hb = $signed({{(COEF_W-SAMPLE_W){1'b0}}, smp_b});
  // centre sample counts twice
  assign h5 = $signed({{(COEF_W-SAMPLE_W-1){1'b0}}, smp_c, 1'b0});

  // ha is h1 in the lower half and h4 in the upper; hb is h2 or h3
  always_comb begin
    unique case ({query_i.lower, query_i.x_gt_y})
      2'b11: begin
        a_d = hb - ha;
        b_d = h5 - ha - hb;
        c_d = ha;
      end
      2'b10: begin
        a_d = h5 - ha - hb;
        b_d = hb - ha;
        c_d = ha;
      end
      2'b01: begin
        a_d = hb + ha - h5;
        b_d = ha - hb;
        c_d = h5 - ha;
      end
      default: begin
        a_d = ha - hb;
        b_d = hb + ha - h5;
        c_d = h5 - ha;
      end
    endcase
  end

  assign x_s     = $signed({1'b0, query_i.frac_x});
  assign y_s     = $signed({1'b0, query_i.frac_y});
  assign ax_prod = a_q * x_s;
  assign by_prod = b_q * y_s;
  assign acc_d   = ACC_W'(ax_q) + ACC_W'(by_prod) + (ACC_W'(c_q) <<< FRAC_W);

  always_ff @(posedge clk_i) begin
    if (step_i.coef_en) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
    end
    if (step_i.mulx_en) begin
      ax_q <= ax_prod;
    end
    if (step_i.sum_en) begin
      acc_q <= acc_d;
    end
  end

  // mode scale, base add and clamp to the signed output range
  always_comb begin
    unique case (query_i.mode)
      MODE_BYTE: scaled = (OUT_W+1)'(acc_q) <<< 1;
      MODE_WORD: scaled = (OUT_W+1)'(acc_q);
      default:   scaled = '0;
    endcase
    total = scaled + (OUT_W+1)'(base_height_i);
    if (total[OUT_W] != total[OUT_W-1]) begin
      height_o = total[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      height_o = total[OUT_W-1:0];
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// testbench for heightmap_triangle_interpolator_unit: a directed row list, then random patch loads
// with queries; every height beat is checked against a known height or a local plane predictor
// depends on hti_pkg and heightmap_triangle_interpolator_unit
module tb_top;
  import hti_pkg::*;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0]     CMD_NONE    = 2'd3;
  localparam logic [1:0]           MODE_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [OUT_W-1:0] HEIGHT_TOP    = 40'sh7F_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0] HEIGHT_BOTTOM = 40'sh80_0000_0000;

  localparam int RANDOM_ITEMS  = 1700;
  localparam int SETTLE_CYCLES = 16;   // slack for beats still in flight
  localparam int CALM_FIRST    = 8;    // phases run with no idling on either side
  localparam int CALM_LAST     = 13;

  // one row of stimulus: either a register write or an item beat
  typedef struct packed {
    logic                     is_cfg;
    logic [CFG_IDX_W-1:0]     reg_index;
    logic [OUT_W-1:0]         reg_data;
    logic [CMD_W-1:0]         cmd;
    logic [INDEX_W-1:0]       idx;
    logic [SAMPLE_W-1:0]      val;
    logic [CELL_W-1:0]        cx;
    logic [CELL_W-1:0]        cy;
    logic [FRAC_W-1:0]        fx;
    logic [FRAC_W-1:0]        fy;
    logic                     has_known;
    logic signed [OUT_W-1:0]  known_height;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [CMD_W-1:0]        command;
  logic [INDEX_W-1:0]      entry_index;
  logic [SAMPLE_W-1:0]     entry_value;
  logic [CELL_W-1:0]       cell_x;
  logic [CELL_W-1:0]       cell_y;
  logic [FRAC_W-1:0]       frac_x;
  logic [FRAC_W-1:0]       frac_y;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] height;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [OUT_W-1:0]        cfg_data;

  // shadow of the block: sample grids and the two registers
  logic [SAMPLE_W-1:0]     corner_shadow [CORNER_DEPTH];
  logic [SAMPLE_W-1:0]     centre_shadow [CENTRE_DEPTH];
  logic [1:0]              mode_shadow;
  logic signed [OUT_W-1:0] base_shadow;

  // heights still owed by the block, oldest first
  logic signed [OUT_W-1:0] pending_heights [$];
  logic signed [OUT_W-1:0] oldest_height;
  // cells whose four corners and centre have all been written (cx * GRID_CELLS + cy)
  int                      ready_cells [$];
  int                      failures;
  logic                    calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  heightmap_triangle_interpolator_unit DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .entry_index_i (entry_index),
    .entry_value_i (entry_value),
    .cell_x_i      (cell_x),
    .cell_y_i      (cell_y),
    .frac_x_i      (frac_x),
    .frac_y_i      (frac_y),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .height_o      (height),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // receiver stalls about a third of the cycles, never during the calm phases
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 32);
  end

  // compare every height beat with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_heights.size() == 0) begin
        $error("height: no beat expected, actual %0d", height);
        failures++;
      end else begin
        oldest_height = pending_heights.pop_front();
        if (height !== oldest_height) begin
          $error("height: expected %0d, actual %0d", oldest_height, height);
          failures++;
        end
      end
    end
  end

  // plane through two corners and twice the centre, picked by fraction sum and order
  function automatic logic signed [OUT_W-1:0] predict_height(input logic [CELL_W-1:0] cx,
                                                             input logic [CELL_W-1:0] cy,
                                                             input logic [FRAC_W-1:0] fx,
                                                             input logic [FRAC_W-1:0] fy);
    longint              x, y, one, h1, h2, h3, h4, h5, a, b, c, scale, sum;
    int                  corner0;
    logic [SAMPLE_W-1:0] keep;
    keep  = 16'hFFFF;
    scale = 0;                           // flat and the spare mode: base height only
    if (mode_shadow == MODE_BYTE) begin
      keep  = 16'h00FF;
      scale = 2;
    end else if (mode_shadow == MODE_WORD) begin
      scale = 1;
    end
    one     = 64'd65536;
    x       = longint'(fx);
    y       = longint'(fy);
    corner0 = int'(cx) * CORNER_SIDE + int'(cy);
    h1 = longint'(corner_shadow[corner0] & keep);
    h2 = longint'(corner_shadow[corner0 + CORNER_SIDE] & keep);
    h3 = longint'(corner_shadow[corner0 + 1] & keep);
    h4 = longint'(corner_shadow[corner0 + CORNER_SIDE + 1] & keep);
    h5 = 2 * longint'(centre_shadow[int'(cx) * GRID_CELLS + int'(cy)] & keep);
    if (x + y < one) begin
      c = h1;
      if (x > y) begin
        a = h2 - h1;
        b = h5 - h1 - h2;
      end else begin
        a = h5 - h1 - h3;
        b = h3 - h1;
      end
    end else begin
      c = h5 - h4;
      if (x > y) begin
        a = h2 + h4 - h5;
        b = h4 - h2;
      end else begin
        a = h4 - h3;
        b = h3 + h4 - h5;
      end
    end
    // sixteen fraction bits already match Q.16, so no rounding step
    sum = (a * x + b * y + c * one) * scale + longint'(base_shadow);
    if (sum > longint'(HEIGHT_TOP)) sum = longint'(HEIGHT_TOP);
    if (sum < longint'(HEIGHT_BOTTOM)) sum = longint'(HEIGHT_BOTTOM);
    return sum[OUT_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  // query fields toggle on write beats and write fields on query beats
  function automatic stim_row_t mk_write(input logic [CMD_W-1:0] cmd, input int idx,
                                         input logic [SAMPLE_W-1:0] val);
    stim_row_t row;
    row     = '0;
    row.cmd = cmd;
    row.idx = INDEX_W'(idx);
    row.val = val;
    row.cx  = CELL_W'($urandom);
    row.cy  = CELL_W'($urandom);
    row.fx  = FRAC_W'($urandom);
    row.fy  = FRAC_W'($urandom);
    return row;
  endfunction

  function automatic stim_row_t mk_query(input int cx, input int cy,
                                         input logic [FRAC_W-1:0] fx, input logic [FRAC_W-1:0] fy);
    stim_row_t row;
    row     = '0;
    row.cmd = CMD_QUERY;
    row.idx = INDEX_W'($urandom);
    row.val = SAMPLE_W'($urandom);
    row.cx  = CELL_W'(cx);
    row.cy  = CELL_W'(cy);
    row.fx  = fx;
    row.fy  = fy;
    return row;
  endfunction

  // query whose height is plain to see: flat mode, a bare corner, or a saturated sum
  function automatic stim_row_t mk_known(input int cx, input int cy, input logic [FRAC_W-1:0] fx,
                                         input logic [FRAC_W-1:0] fy,
                                         input logic signed [OUT_W-1:0] h);
    stim_row_t row;
    row              = mk_query(cx, cy, fx, fy);
    row.has_known    = 1'b1;
    row.known_height = h;
    return row;
  endfunction

  function automatic stim_row_t mk_cfg(input logic [CFG_IDX_W-1:0] index,
                                       input logic [OUT_W-1:0] data);
    stim_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.reg_index = index;
    row.reg_data  = data;
    return row;
  endfunction

  // one item beat; valid stays high from the previous beat unless an idle cycle comes first
  task automatic send_item(input stim_row_t row);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    command     <= row.cmd;
    entry_index <= row.idx;
    entry_value <= row.val;
    cell_x      <= row.cx;
    cell_y      <= row.cy;
    frac_x      <= row.fx;
    frac_y      <= row.fy;
    do @(posedge clk); while (!in_ready);
    // beat taken at this edge: update the shadow or book the height owed
    case (row.cmd)
      CMD_WR_CORNER: if (int'(row.idx) < CORNER_DEPTH) corner_shadow[row.idx] = row.val;
      CMD_WR_CENTRE: if (int'(row.idx) < CENTRE_DEPTH) centre_shadow[row.idx] = row.val;
      CMD_QUERY:     pending_heights.push_back(row.has_known ? row.known_height :
                                               predict_height(row.cx, row.cy, row.fx, row.fy));
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [OUT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_HEIGHT_MODE: mode_shadow = data[1:0];
      REG_BASE_HEIGHT: base_shadow = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // sender holds off until every height has come back, then lets writes in flight finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // beats the block must drop: spare command, writes past the end of either grid
  task automatic send_noise();
    stim_row_t row;
    case ($urandom_range(2))
      0:       row = mk_write(CMD_NONE, $urandom_range(32767), pick_sample());
      1:       row = mk_write(CMD_WR_CORNER, $urandom_range(CORNER_DEPTH, 32767), pick_sample());
      default: row = mk_write(CMD_WR_CENTRE, $urandom_range(CENTRE_DEPTH, 32767), pick_sample());
    endcase
    send_item(row);
  endtask

  initial begin : stimulus
    stim_row_t        directed_rows [$];
    int               patch_cells [$];
    int               done_items, phase, px, py, pw, ph, pick_cell, corner_pick;
    logic [FRAC_W-1:0] fx, fy;
    logic [1:0]       mode;
    logic [OUT_W-1:0] reg_word;
    logic [31:0]      word;

    rst_n       = 1'b0;
    calm        = 1'b0;
    failures    = 0;
    in_valid    = 1'b0;
    command     = CMD_NONE;
    entry_index = '0;
    entry_value = '0;
    cell_x      = '0;
    cell_y      = '0;
    frac_x      = '0;
    frac_y      = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_HEIGHT_MODE;
    cfg_data    = '0;
    mode_shadow = MODE_FLAT;
    base_shadow = '0;

    // cell (0,0) fully loaded, flat query right after reset gives zero
    directed_rows.push_back(mk_write(CMD_WR_CORNER, 0, 16'h1234));
    directed_rows.push_back(mk_write(CMD_WR_CORNER, 1, 16'hFFFF));
    directed_rows.push_back(mk_write(CMD_WR_CORNER, CORNER_SIDE, 16'h0000));
    directed_rows.push_back(mk_write(CMD_WR_CORNER, CORNER_SIDE + 1, 16'h80A5));
    directed_rows.push_back(mk_write(CMD_WR_CENTRE, 0, 16'h7F01));
    directed_rows.push_back(mk_known(0, 0, 16'h0000, 16'h0000, '0));
    // spare command and out-of-range addresses are dropped
    directed_rows.push_back(mk_write(CMD_NONE, 0, 16'hDEAD));
    directed_rows.push_back(mk_write(CMD_WR_CORNER, CORNER_DEPTH, 16'hBEEF));
    directed_rows.push_back(mk_write(CMD_WR_CENTRE, CENTRE_DEPTH, 16'hBEEF));
    // far corner cell (127,127), last entry of each grid
    directed_rows.push_back(mk_write(CMD_WR_CORNER, CORNER_DEPTH - CORNER_SIDE - 2, 16'hFFFF));
    directed_rows.push_back(mk_write(CMD_WR_CORNER, CORNER_DEPTH - CORNER_SIDE - 1, 16'h00FF));
    directed_rows.push_back(mk_write(CMD_WR_CORNER, CORNER_DEPTH - 2, 16'hFF00));
    directed_rows.push_back(mk_write(CMD_WR_CORNER, CORNER_DEPTH - 1, 16'hFFFF));
    directed_rows.push_back(mk_write(CMD_WR_CENTRE, CENTRE_DEPTH - 1, 16'hFFFF));
    // sixteen-bit mode: bare corner at zero fraction, diagonal, edges
    directed_rows.push_back(mk_cfg(REG_HEIGHT_MODE, OUT_W'(MODE_WORD)));
    directed_rows.push_back(mk_known(0, 0, 16'h0000, 16'h0000, 40'sh00_1234_0000));
    directed_rows.push_back(mk_query(0, 0, 16'h8000, 16'h8000));
    directed_rows.push_back(mk_query(127, 127, 16'hFFFF, 16'h0000));
    directed_rows.push_back(mk_query(127, 127, 16'h0000, 16'hFFFF));
    directed_rows.push_back(mk_query(127, 127, 16'hFFFF, 16'hFFFF));
    // eight-bit mode uses the low byte only, doubled
    directed_rows.push_back(mk_cfg(REG_HEIGHT_MODE, OUT_W'(MODE_BYTE)));
    directed_rows.push_back(mk_query(0, 0, 16'h4000, 16'h1000));
    directed_rows.push_back(mk_query(127, 127, 16'h7FFF, 16'h7FFF));
    // spare mode acts as flat
    directed_rows.push_back(mk_cfg(REG_HEIGHT_MODE, OUT_W'(MODE_SPARE)));
    directed_rows.push_back(mk_known(0, 0, 16'h1234, 16'h5678, '0));
    // top base plus a positive plane saturates
    directed_rows.push_back(mk_cfg(REG_BASE_HEIGHT, HEIGHT_TOP));
    directed_rows.push_back(mk_cfg(REG_HEIGHT_MODE, OUT_W'(MODE_WORD)));
    directed_rows.push_back(mk_known(0, 0, 16'h0000, 16'h0000, HEIGHT_TOP));
    // bottom base in flat mode comes straight through
    directed_rows.push_back(mk_cfg(REG_BASE_HEIGHT, HEIGHT_BOTTOM));
    directed_rows.push_back(mk_cfg(REG_HEIGHT_MODE, OUT_W'(MODE_FLAT)));
    directed_rows.push_back(mk_known(127, 127, 16'hFFFF, 16'hFFFF, HEIGHT_BOTTOM));
    // small negative base under a real plane
    directed_rows.push_back(mk_cfg(REG_BASE_HEIGHT, -40'sd1048576));
    directed_rows.push_back(mk_cfg(REG_HEIGHT_MODE, OUT_W'(MODE_WORD)));
    directed_rows.push_back(mk_query(0, 0, 16'h8000, 16'h7FFF));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
      end else begin
        send_item(directed_rows[i]);
      end
    end
    ready_cells.push_back(0);
    ready_cells.push_back(CENTRE_DEPTH - 1);

    // random phases: new setting, load a small patch, then query it with rewrites and noise
    done_items = 0;
    phase      = 0;
    while (done_items < RANDOM_ITEMS) begin
      calm = (phase >= CALM_FIRST && phase <= CALM_LAST);
      settle();

      case ($urandom_range(19))
        0, 1:    mode = MODE_FLAT;
        2:       mode = MODE_SPARE;
        3, 4, 5, 6, 7, 8, 9, 10: mode = MODE_BYTE;
        default: mode = MODE_WORD;
      endcase
      reg_word = ($urandom_range(3) == 0) ? OUT_W'({$urandom, $urandom}) : '0;
      reg_word[1:0] = mode;
      write_reg(REG_HEIGHT_MODE, reg_word);

      word = $urandom;
      case ($urandom_range(9))
        0:       write_reg(REG_BASE_HEIGHT, '0);
        1:       write_reg(REG_BASE_HEIGHT, HEIGHT_TOP);
        2:       write_reg(REG_BASE_HEIGHT, HEIGHT_BOTTOM);
        3:       write_reg(REG_BASE_HEIGHT, HEIGHT_TOP - (OUT_W'(word) << 2));   // near the ceiling
        4:       write_reg(REG_BASE_HEIGHT, OUT_W'({$urandom, word}));
        5, 6:    write_reg(REG_BASE_HEIGHT, {{8{word[31]}}, word});
        default: ;                                                         // keep the old base
      endcase
      if ($urandom_range(4) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, OUT_W'({$urandom, $urandom}));

      // patch of 1..4 cells a side, often pushed against a grid edge
      pw = $urandom_range(1, 4);
      ph = $urandom_range(1, 4);
      case ($urandom_range(4))
        0:       px = 0;
        1:       px = GRID_CELLS - pw;
        default: px = $urandom_range(GRID_CELLS - pw);
      endcase
      case ($urandom_range(4))
        0:       py = 0;
        1:       py = GRID_CELLS - ph;
        default: py = $urandom_range(GRID_CELLS - ph);
      endcase
      for (int i = 0; i <= pw; i++) begin
        for (int j = 0; j <= ph; j++) begin
          if ($urandom_range(19) == 0) send_noise();
          send_item(mk_write(CMD_WR_CORNER, (px + i) * CORNER_SIDE + py + j, pick_sample()));
          done_items++;
        end
      end
      patch_cells.delete();
      for (int i = 0; i < pw; i++) begin
        for (int j = 0; j < ph; j++) begin
          if ($urandom_range(19) == 0) send_noise();
          send_item(mk_write(CMD_WR_CENTRE, (px + i) * GRID_CELLS + py + j, pick_sample()));
          done_items++;
          patch_cells.push_back((px + i) * GRID_CELLS + py + j);
          ready_cells.push_back((px + i) * GRID_CELLS + py + j);
        end
      end

      repeat ($urandom_range(15, 40)) begin
        pick_cell = ($urandom_range(99) < 85)
                  ? patch_cells[$urandom_range(patch_cells.size() - 1)]
                  : ready_cells[$urandom_range(ready_cells.size() - 1)];
        case ($urandom_range(99)) inside
          [0:4]: send_noise();
          [5:11]: begin
            // fresh value for a sample the cell already holds, so it stays loaded
            if ($urandom_range(4) == 0) begin
              send_item(mk_write(CMD_WR_CENTRE, pick_cell, pick_sample()));
            end else begin
              corner_pick = (pick_cell / GRID_CELLS + $urandom_range(1)) * CORNER_SIDE
                          + pick_cell % GRID_CELLS + $urandom_range(1);
              send_item(mk_write(CMD_WR_CORNER, corner_pick, pick_sample()));
            end
            done_items++;
          end
          default: begin
            case ($urandom_range(9))
              0: begin
                fx = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
                fy = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
              end
              1: begin                           // on the x = y diagonal
                fx = FRAC_W'($urandom);
                fy = fx;
              end
              2: begin                           // sum exactly one: upper triangles
                fx = FRAC_W'($urandom_range(1, 65535));
                fy = FRAC_W'(17'h1_0000 - {1'b0, fx});
              end
              3: begin                           // sum one lsb short of one
                fx = FRAC_W'($urandom);
                fy = ~fx;
              end
              4: begin                           // x and y one apart
                fx = FRAC_W'($urandom_range(65534));
                fy = fx + 16'd1;
                if ($urandom_range(1)) {fx, fy} = {fy, fx};
              end
              default: begin
                fx = FRAC_W'($urandom);
                fy = FRAC_W'($urandom);
              end
            endcase
            send_item(mk_query(pick_cell / GRID_CELLS, pick_cell % GRID_CELLS, fx, fy));
            done_items++;
          end
        endcase
      end
      phase++;
    end

    calm = 1'b0;
    settle();
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
